// ===== rtl/terec_pkg.sv =====
// Package: shared constants, types and helper functions for the record encoder.
package terec_pkg;

   localparam int unsigned WordWidth   = 64;
   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned VarMaxBytes = 10;
   localparam int unsigned NumSegs     = 7;
   localparam int unsigned SegIdxWidth = 3;
   localparam int unsigned ByteIdxWidth = 4;

   localparam logic [CsrIdxWidth-1:0] CSR_TS_BASE     = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_BASE_FRAME  = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_SCOPE_CODE  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_COUNT_CODE  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_UTAG_CODE   = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_STAG_CODE   = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CSR_RTAG_CODE   = 3'd6;

   // Segment kinds: one byte, a varint of a 64-bit value, or eight raw bytes.
   typedef enum logic [1:0] {
      SEG_NONE   = 2'd0,
      SEG_BYTE   = 2'd1,
      SEG_VARINT = 2'd2,
      SEG_RAW    = 2'd3
   } seg_kind_type;

   typedef struct packed {
      seg_kind_type         kind;
      logic [WordWidth-1:0] value;
   } seg_type;

   typedef struct packed {
      logic [63:0] timestamp_base;
      logic [63:0] base_frame;
      logic [1:0]  scope_type_code;
      logic [1:0]  counter_type_code;
      logic [7:0]  unsigned_tag_code;
      logic [7:0]  signed_tag_code;
      logic [7:0]  raw_tag_code;
   } csr_type;

   // One trace event record as it crosses the req_ channel, fields in order.
   typedef struct packed {
      logic [1:0]           record_type;
      logic [WordWidth-1:0] track_id;
      logic [WordWidth-1:0] frame_number;
      logic [WordWidth-1:0] begin_tick;
      logic [WordWidth-1:0] end_tick;
      logic [WordWidth-1:0] name_id;
      logic [WordWidth-1:0] counter_bits;
   } req_word_type;

   // One encoded byte as it leaves on the rsp_ channel.
   typedef struct packed {
      logic [ByteWidth-1:0] out_byte;
      logic                 last_byte;
   } rsp_word_type;

   // Number of bytes a varint of v takes, 1 to 10.
   function automatic logic [ByteIdxWidth-1:0] varint_len(input logic [WordWidth-1:0] v);
      logic [ByteIdxWidth-1:0] n;
      n = ByteIdxWidth'(1);
      for (int i = 1; i < VarMaxBytes; i++) begin
         if ((v >> (7 * i)) != '0) n = ByteIdxWidth'(i + 1);
      end
      return n;
   endfunction

   function automatic logic [ByteIdxWidth-1:0] seg_len(input seg_type s);
      logic [ByteIdxWidth-1:0] n;
      case (s.kind)
         SEG_NONE:   n = '0;
         SEG_BYTE:   n = ByteIdxWidth'(1);
         SEG_VARINT: n = varint_len(s.value);
         SEG_RAW:    n = ByteIdxWidth'(8);
         default:    n = '0;
      endcase
      return n;
   endfunction

endpackage

// ===== rtl/terec_stream_if.sv =====
// Interface: valid/ready channel carrying a parameterised payload.
interface terec_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/terec_segmenter.sv =====
// Segmenter: turns one record and the registers into a list of encoding segments.
module terec_segmenter import terec_pkg::*; (
   input  logic [1:0]           record_type,
   input  logic [WordWidth-1:0] track_id,
   input  logic [WordWidth-1:0] frame_number,
   input  logic [WordWidth-1:0] begin_tick,
   input  logic [WordWidth-1:0] end_tick,
   input  logic [WordWidth-1:0] name_id,
   input  logic [WordWidth-1:0] counter_bits,
   input  csr_type              csr,
   output seg_type              segs [NumSegs]
);
   logic [WordWidth-1:0] frame_delta, begin_delta, dur;
   logic                 is_scope, is_count, has_track;
   logic                 sgn;
   logic [10:0]          ex;
   logic [51:0]          man;
   logic [52:0]          full;
   logic [5:0]           e;
   logic [WordWidth-1:0] mag, frac_mask;
   logic                 exp_ok, integral;

   always_comb begin
      has_track   = track_id != '0;
      frame_delta = frame_number - csr.base_frame;
      begin_delta = (begin_tick >= csr.timestamp_base) ? begin_tick - csr.timestamp_base : '0;
      dur         = (end_tick >= begin_tick) ? end_tick - begin_tick : '0;
      is_scope    = record_type == csr.scope_type_code;
      is_count    = !is_scope && record_type == csr.counter_type_code;

      sgn  = counter_bits[63];
      ex   = counter_bits[62:52];
      man  = counter_bits[51:0];
      full = {1'b1, man};
      exp_ok = ex >= 11'd1023 && ex <= 11'd1086;
      e    = 6'(ex - 11'd1023);
      if (e >= 6'd52) begin
         mag       = WordWidth'(full) << (e - 6'd52);
         frac_mask = '0;
      end else begin
         mag       = WordWidth'(full) >> (6'd52 - e);
         frac_mask = (WordWidth'(1) << (6'd52 - e)) - WordWidth'(1);
      end
      integral = (WordWidth'(full) & frac_mask) == '0;

      segs[0] = '{SEG_BYTE, {61'd0, has_track, record_type}};
      segs[1] = has_track ? '{SEG_VARINT, track_id} : '{SEG_NONE, '0};
      segs[2] = '{SEG_VARINT, {frame_delta[62:0], 1'b0} ^ {WordWidth{frame_delta[63]}}};
      segs[3] = '{SEG_VARINT, begin_delta};
      segs[4] = '{SEG_VARINT, name_id};
      segs[5] = '{SEG_NONE, '0};
      segs[6] = '{SEG_NONE, '0};
      if (is_scope) begin
         segs[5] = '{SEG_VARINT, dur};
      end else if (is_count) begin
         if (counter_bits == '0) begin
            segs[5] = '{SEG_BYTE, {56'd0, csr.unsigned_tag_code}};
            segs[6] = '{SEG_VARINT, '0};
         end else if (exp_ok && integral && !sgn) begin
            segs[5] = '{SEG_BYTE, {56'd0, csr.unsigned_tag_code}};
            segs[6] = '{SEG_VARINT, mag};
         end else if (exp_ok && integral && (e <= 6'd62 || man == '0)) begin
            segs[5] = '{SEG_BYTE, {56'd0, csr.signed_tag_code}};
            segs[6] = '{SEG_VARINT, (mag << 1) - WordWidth'(1)};
         end else begin
            segs[5] = '{SEG_BYTE, {56'd0, csr.raw_tag_code}};
            segs[6] = '{SEG_RAW, counter_bits};
         end
      end
   end
endmodule

// ===== rtl/trace_event_record_encoder_top.sv =====
// Top level: trace event record encoder, one record in, a stream of bytes out.
//
//   Channel   Direction  Word                              Handshake
//   req_      in         one trace event record            valid/ready
//   rsp_      out        out_byte, last_byte               valid/ready
//   csr_      in         index, 64-bit data                write enable only
//
// A record is cut into segments by the segmenter, and the segments are
// registered on acceptance; the serialiser then sends one byte per cycle
// while rsp_ is ready, and a record has 4 to 52 bytes. The byte-per-cycle
// output sets the rate. The input register refills in the cycle the last
// byte of the previous record leaves, so records follow with no gap. Reset
// is synchronous and active high; it clears control state and resets the
// configuration registers. A stall on the rsp_ side holds the current byte.
module trace_event_record_encoder_top import terec_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   terec_stream_if.sink           req,
   terec_stream_if.source         rsp,
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [WordWidth-1:0]   csr_data
);
   csr_type csr_ff;

   // Configuration registers; the user is to write them only while idle, a rule unenforced by the block itself.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '{64'd0, 64'd0, 2'd1, 2'd2, 8'd0, 8'd1, 8'd2};
      end else if (csr_we) begin
         case (csr_index)
            CSR_TS_BASE:    csr_ff.timestamp_base    <= csr_data;
            CSR_BASE_FRAME: csr_ff.base_frame        <= csr_data;
            CSR_SCOPE_CODE: csr_ff.scope_type_code   <= csr_data[1:0];
            CSR_COUNT_CODE: csr_ff.counter_type_code <= csr_data[1:0];
            CSR_UTAG_CODE:  csr_ff.unsigned_tag_code <= csr_data[7:0];
            CSR_STAG_CODE:  csr_ff.signed_tag_code   <= csr_data[7:0];
            CSR_RTAG_CODE:  csr_ff.raw_tag_code      <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Segments of the record being sent, with a segment and a byte pointer.
   seg_type                 segs_ff [NumSegs];
   seg_type                 segs_in [NumSegs];
   logic                    busy_ff;
   logic [SegIdxWidth-1:0]  seg_ff, seg_in;
   logic [ByteIdxWidth-1:0] byte_ff, byte_in;

   terec_segmenter u_seg (
      .record_type (req.data.record_type),
      .track_id    (req.data.track_id),
      .frame_number(req.data.frame_number),
      .begin_tick  (req.data.begin_tick),
      .end_tick    (req.data.end_tick),
      .name_id     (req.data.name_id),
      .counter_bits(req.data.counter_bits),
      .csr         (csr_ff),
      .segs        (segs_in)
   );

   seg_type                 cur;
   logic [ByteIdxWidth-1:0] cur_len;
   logic                    seg_end, rec_end, more;
   logic [WordWidth-1:0]    shifted;
   logic [7:0]              cur_byte;

   always_comb begin
      cur     = segs_ff[seg_ff];
      cur_len = seg_len(cur);
      seg_end = byte_ff == cur_len - ByteIdxWidth'(1);
      more    = 1'b0;
      for (int s = 0; s < NumSegs; s++) begin
         if (SegIdxWidth'(s) > seg_ff && segs_ff[s].kind != SEG_NONE) more = 1'b1;
      end
      rec_end = seg_end && !more;
      case (cur.kind)
         SEG_BYTE:   cur_byte = cur.value[7:0];
         SEG_VARINT: begin
            shifted  = cur.value >> (7 * byte_ff);
            cur_byte = {!seg_end, shifted[6:0]};
         end
         SEG_RAW: begin
            shifted  = cur.value >> (8 * byte_ff);
            cur_byte = shifted[7:0];
         end
         default:    cur_byte = '0;
      endcase
      if (cur.kind != SEG_VARINT) shifted = '0;
   end

   assign rsp.valid            = busy_ff;
   assign rsp.data.out_byte    = cur_byte;
   assign rsp.data.last_byte   = rec_end;
   assign req.ready            = !busy_ff || (rsp.ready && rec_end);

   always_comb begin
      seg_in  = seg_ff;
      byte_in = byte_ff;
      if (busy_ff && rsp.ready) begin
         if (seg_end) begin
            byte_in = '0;
            // Skip to the next segment that holds bytes.
            for (int s = NumSegs - 1; s >= 0; s--) begin
               if (SegIdxWidth'(s) > seg_ff && segs_ff[s].kind != SEG_NONE)
                  seg_in = SegIdxWidth'(s);
            end
         end else begin
            byte_in = byte_ff + ByteIdxWidth'(1);
         end
      end
      if (req.valid && req.ready) begin
         seg_in  = '0;
         byte_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         seg_ff  <= '0;
         byte_ff <= '0;
      end else begin
         seg_ff  <= seg_in;
         byte_ff <= byte_in;
         if (req.valid && req.ready) busy_ff <= 1'b1;
         else if (rsp.ready && rec_end) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) segs_ff <= segs_in;
   end
endmodule
